@@ rtl/pcfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pcfc_pkg;

	typedef enum logic [1:0] {
		ENC_UNORM8  = 2'd0,
		ENC_UNORM16 = 2'd1,
		ENC_FLOAT32 = 2'd2,
		ENC_UINT32  = 2'd3
	} enc_t;

	// register indexes on the apb port
	localparam logic [1:0] REG_SRC_TYPE = 2'd0;
	localparam logic [1:0] REG_SRC_COMP = 2'd1;
	localparam logic [1:0] REG_DST_TYPE = 2'd2;
	localparam logic [1:0] REG_DST_COMP = 2'd3;

	localparam int unsigned NUM_CH = 4;
	localparam logic [31:0] ONE_F32 = 32'h3F80_0000;

	typedef struct packed {
		logic [31:0] in_ch0;
		logic [31:0] in_ch1;
		logic [31:0] in_ch2;
		logic [31:0] in_ch3;
		logic        last_in;
	} pix_in_t;

	typedef struct packed {
		logic [31:0] out_ch0;
		logic [31:0] out_ch1;
		logic [31:0] out_ch2;
		logic [31:0] out_ch3;
		logic        last_out;
	} pix_out_t;

	// after decode: raw bits, mantissa product, leading zero count
	typedef struct packed {
		logic [31:0] raw;
		logic [39:0] prod;
		logic [4:0]  lz;
	} lane_s1_t;

	// after normalize: rounded scale product, shift, int to float operand, float to uint32
	typedef struct packed {
		logic [31:0] raw;
		logic [24:0] rnd;
		logic [4:0]  ushift;
		logic        uzero;
		logic [31:0] norm;
		logic [31:0] f2u;
		logic [4:0]  lz;
	} lane_s2_t;

endpackage
`default_nettype wire

@@ rtl/pixel_channel_format_convert.sv @@
`timescale 1ns / 1ps
`default_nettype none
// pipeline: a src transfer passes the registered decode, normalize and round stages before dst_valid
// throughput: 1 pixel per cycle while dst_ready stays high; each stage holds one pixel and moves when the next frees
// reset: arst_n clears all stage valid bits and sets src/dst type to unorm8, counts to 4
// configuration is read by the pipeline directly, so write it only while empty
module pixel_channel_format_convert
	import pcfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        src_valid,
	output logic             src_ready,
	input  wire pix_in_t     src_data,
	output logic             dst_valid,
	input  wire logic        dst_ready,
	output pix_out_t         dst_data
);

	enc_t       src_type_q, dst_type_q;
	logic [2:0] src_comp_q, dst_comp_q;

	logic       v_s1, v_s2, v_s3;
	logic       last_s1, last_s2;
	lane_s1_t   lane_s1 [NUM_CH];
	lane_s2_t   lane_s2 [NUM_CH];
	pix_out_t   out_s3;
	logic       adv1, adv2, adv3;
	logic [2:0] ns, nd;
	logic [31:0] in_ch [NUM_CH];
	logic [31:0] res_ch [NUM_CH];

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_type_q <= ENC_UNORM8;
			src_comp_q <= 3'd4;
			dst_type_q <= ENC_UNORM8;
			dst_comp_q <= 3'd4;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SRC_TYPE: src_type_q <= enc_t'(pwdata[1:0]);
				REG_SRC_COMP: src_comp_q <= pwdata[2:0];
				REG_DST_TYPE: dst_type_q <= enc_t'(pwdata[1:0]);
				REG_DST_COMP: dst_comp_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SRC_TYPE: prdata = {30'd0, src_type_q};
			REG_SRC_COMP: prdata = {29'd0, src_comp_q};
			REG_DST_TYPE: prdata = {30'd0, dst_type_q};
			REG_DST_COMP: prdata = {29'd0, dst_comp_q};
			default:      prdata = 32'd0;
		endcase
	end

	// ---------------- helpers ----------------
	function automatic logic [4:0] lzc32(input logic [31:0] w);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (w[i]) n = 5'(31 - i);
		end
		return n;
	endfunction

	function automatic logic [31:0] max_of(input enc_t e);
		logic [31:0] m;
		case (e)
			ENC_UNORM8:  m = 32'h0000_00FF;
			ENC_UNORM16: m = 32'h0000_FFFF;
			ENC_FLOAT32: m = ONE_F32;
			default:     m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [2:0] clamp_cnt(input logic [2:0] c);
		return (c > 3'd4) ? 3'd4 : c;
	endfunction

	// stage a: mantissa times 255 or 65535, leading zeros of the integer source
	function automatic lane_s1_t lane_a(input logic [31:0] v, input enc_t se, input enc_t de);
		lane_s1_t   r;
		logic [23:0] m24;
		logic [31:0] w;
		m24 = {(v[30:23] != 8'd0), v[22:0]};
		case (se)
			ENC_UNORM8:  w = {v[7:0], 24'd0};
			ENC_UNORM16: w = {v[15:0], 16'd0};
			default:     w = v;
		endcase
		r.raw  = v;
		// times 2^n - 1 as a shift and a subtract
		r.prod = (de == ENC_UNORM8) ? ({8'd0, m24, 8'd0} - {16'd0, m24})
			: ({m24, 16'd0} - {16'd0, m24});
		r.lz   = lzc32(w);
		return r;
	endfunction

	// stage b: round the scale product, normalize integers, float to uint32
	function automatic lane_s2_t lane_b(input lane_s1_t a, input enc_t se, input enc_t de);
		lane_s2_t    r;
		logic [7:0]  ex;
		logic        top, g, st;
		logic [23:0] keep;
		logic [9:0]  sh;
		logic [23:0] m24;
		logic [54:0] t;
		logic [47:0] s48;
		logic [47:0] tt;
		ex = a.raw[30:23];
		if (de == ENC_UNORM8) begin
			top  = a.prod[31];
			keep = top ? a.prod[31:8] : a.prod[30:7];
			g    = top ? a.prod[7] : a.prod[6];
			st   = top ? (|a.prod[6:0]) : (|a.prod[5:0]);
			sh   = 10'd142 - {2'd0, ex} + {9'd0, ~top};
		end else begin
			top  = a.prod[39];
			keep = top ? a.prod[39:16] : a.prod[38:15];
			g    = top ? a.prod[15] : a.prod[14];
			st   = top ? (|a.prod[14:0]) : (|a.prod[13:0]);
			sh   = 10'd134 - {2'd0, ex} + {9'd0, ~top};
		end
		r.rnd    = {1'b0, keep} + {24'd0, g & (st | keep[0])};
		r.uzero  = sh > 10'd24;
		r.ushift = sh[4:0];

		// float to uint32, truncating
		m24 = {(ex != 8'd0), a.raw[22:0]};
		t   = 55'd0;
		if ((ex == 8'hFF && a.raw[22:0] != 23'd0) || a.raw[31] || ex < 8'd127)
			r.f2u = 32'd0;
		else if (ex >= 8'd159)
			r.f2u = 32'hFFFF_FFFF;
		else begin
			t = {31'd0, m24} << (ex - 8'd127);
			r.f2u = t[54:23];
		end

		// unorm / (2^w - 1) is the source repeated forever after the point
		if (se == ENC_UNORM8) s48 = {6{a.raw[7:0]}};
		else                  s48 = {3{a.raw[15:0]}};
		tt = s48 << a.lz;
		if (se == ENC_UINT32) r.norm = a.raw << a.lz;
		else                  r.norm = {tt[47:23], 7'd0};
		r.raw = a.raw;
		r.lz  = a.lz;
		return r;
	endfunction

	function automatic logic [31:0] to_f32(input logic [31:0] nv, input logic [4:0] lz,
		input logic force_st, input logic [7:0] base);
		logic        g, st;
		logic [24:0] rm;
		logic [7:0]  e8;
		g  = nv[7];
		st = force_st | (|nv[6:0]);
		rm = {1'b0, nv[31:8]} + {24'd0, g & (st | nv[8])};
		e8 = base - {3'd0, lz};
		if (rm[24]) return {1'b0, e8 + 8'd1, 23'd0};
		return {1'b0, e8, rm[22:0]};
	endfunction

	function automatic logic [31:0] f_to_unorm(input lane_s2_t b, input logic [31:0] mx);
		logic [7:0]  ex;
		logic [24:0] q;
		ex = b.raw[30:23];
		q  = b.rnd >> b.ushift;
		if (ex == 8'hFF && b.raw[22:0] != 23'd0) return mx;
		if (b.raw[31]) return 32'd0;
		if (ex >= 8'd127) return mx;
		if (b.uzero) return 32'd0;
		return {7'd0, q} & mx;
	endfunction

	// stage c: rounding and the final encoding mux
	function automatic logic [31:0] lane_c(input lane_s2_t b, input enc_t se, input enc_t de);
		logic [31:0] r;
		logic [15:0] n;
		n = (se == ENC_UNORM8) ? {8'd0, b.raw[7:0]} : b.raw[15:0];
		case (de)
			ENC_UNORM8: begin
				case (se)
					ENC_UNORM16: r = {24'd0, b.raw[15:8]};
					ENC_FLOAT32: r = f_to_unorm(b, 32'h0000_00FF);
					default:     r = {24'd0, b.raw[7:0]};
				endcase
			end
			ENC_UNORM16: begin
				case (se)
					ENC_UNORM8:  r = {16'd0, b.raw[7:0], {8{b.raw[0]}}};
					ENC_FLOAT32: r = f_to_unorm(b, 32'h0000_FFFF);
					default:     r = {16'd0, b.raw[15:0]};
				endcase
			end
			ENC_FLOAT32: begin
				case (se)
					ENC_FLOAT32: r = b.raw;
					ENC_UINT32:  r = (b.raw == 32'd0) ? 32'd0
						: to_f32(b.norm, b.lz, 1'b0, 8'd158);
					default: begin
						if (n == 16'd0) r = 32'd0;
						else if ({16'd0, n} == max_of(se)) r = ONE_F32;
						else r = to_f32(b.norm, b.lz, 1'b1, 8'd126);
					end
				endcase
			end
			default: begin
				case (se)
					ENC_UNORM8, ENC_UNORM16: r = {31'd0, n != 16'd0};
					ENC_FLOAT32: r = b.f2u;
					default:     r = b.raw;
				endcase
			end
		endcase
		return r;
	endfunction

	// ---------------- pipeline ----------------
	assign adv3      = !v_s3 || dst_ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign src_ready = adv1;
	assign dst_valid = v_s3;
	assign dst_data  = out_s3;

	assign in_ch[0] = src_data.in_ch0;
	assign in_ch[1] = src_data.in_ch1;
	assign in_ch[2] = src_data.in_ch2;
	assign in_ch[3] = src_data.in_ch3;

	assign ns = clamp_cnt(src_comp_q);
	assign nd = clamp_cnt(dst_comp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= src_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && src_valid) begin
			last_s1 <= src_data.last_in;
			for (int i = 0; i < NUM_CH; i++)
				lane_s1[i] <= lane_a(in_ch[i], src_type_q, dst_type_q);
		end
		if (adv2 && v_s1) begin
			last_s2 <= last_s1;
			for (int i = 0; i < NUM_CH; i++)
				lane_s2[i] <= lane_b(lane_s1[i], src_type_q, dst_type_q);
		end
		if (adv3 && v_s2) begin
			out_s3 <= '{out_ch0: res_ch[0], out_ch1: res_ch[1], out_ch2: res_ch[2],
				out_ch3: res_ch[3], last_out: last_s2};
		end
	end

	// missing channels default to zero, alpha to the destination maximum
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			if (3'(i) >= nd)
				res_ch[i] = 32'd0;
			else if (3'(i) < ns)
				res_ch[i] = lane_c(lane_s2[i], src_type_q, dst_type_q);
			else if (i == NUM_CH - 1)
				res_ch[i] = max_of(dst_type_q);
			else
				res_ch[i] = 32'd0;
		end
	end

endmodule
`default_nettype wire
